// File: src/lane_row_boundary_tracer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lane row boundary tracer.
// ---------------------------------------------------------------------------
`ifndef LANE_ROW_BOUNDARY_TRACER_MACROS_SVH
`define LANE_ROW_BOUNDARY_TRACER_MACROS_SVH
`ifndef SYNTHESIS
`define LRBT_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lrbt check failed");
`define LRBT_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lrbt check failed");
`else
`define LRBT_ASSERT_IMP(label, clk, rst_n, a, b)
`define LRBT_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// File: src/lrbt_pkg.sv
// ---------------------------------------------------------------------------
// lrbt_pkg
// Shared types and constants of the lane row boundary tracer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lrbt_pkg;
	localparam int MAX_RUNS_PER_ROW_DEF = 32;
	localparam int IMAGE_WIDTH_DEF = 1024;
	localparam int CW = 10;
	localparam int QW = 18;

	typedef enum logic [1:0] {
		KIND_BOUNDARY = 2'd0,
		KIND_LEFT     = 2'd1,
		KIND_RIGHT    = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NEAREST = 2'd0,
		MODE_FIRST   = 2'd1,
		MODE_LAST    = 2'd2,
		MODE_ALT     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MAX_GAP  = 3'd0,
		REG_MODE     = 3'd1,
		REG_USE_BOT  = 3'd2,
		REG_BOT_X    = 3'd3,
		REG_HIST_X   = 3'd4,
		REG_BR_CAP   = 3'd5
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL_RD,
		ST_SEL,
		ST_BR_RD,
		ST_BR,
		ST_EMIT,
		ST_SMOOTH
	} state_t;
endpackage

// File: src/lane_row_boundary_tracer.sv
// ---------------------------------------------------------------------------
// lane_row_boundary_tracer
// Row-by-row lane boundary selection from buffered mask runs.
// ---------------------------------------------------------------------------
// Run beats are written into a small run buffer; the block is ready for them
// only while the sequencer is idle and the output register is empty. A beat
// with tlast ends the row: a sequencer then walks the buffer twice through one
// shared distance/compare unit, first to choose the lane run (a RAM read step
// and a compare step per buffered run), then again to emit every other run as
// a left or right branch (a read step and a branch step per run, plus any
// output stall), and finally emits the boundary and, for a row with runs,
// smooths the tracked centre in one more step as a weighted sum of two
// products. No result beat is lost while the output is stalled: the sequencer
// waits in its branch and emit steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lane_row_boundary_tracer_macros.svh"
module lane_row_boundary_tracer
	import lrbt_pkg::*;
#(
	parameter int MAX_RUNS_PER_ROW = MAX_RUNS_PER_ROW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: row[9:0], row_empty[10], run_start[20:11], run_end[30:21], zero fill
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	// tuser: frame_start
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: out_row[9:0], left_or_center[19:10], right_col[29:20],
	// filled[30], runs_dropped[31]
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	// tuser: kind
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_wdata
);
	localparam int AW = $clog2(MAX_RUNS_PER_ROW);
	localparam int NW = $clog2(MAX_RUNS_PER_ROW + 1);
	localparam logic [NW-1:0] NMAX = NW'(MAX_RUNS_PER_ROW);

	// Configuration registers.
	logic [9:0]  max_gap_q;
	mode_t       mode_q;
	logic        use_bot_q;
	logic [17:0] bot_x_q, hist_x_q;
	logic [15:0] br_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= '0;
			mode_q    <= MODE_NEAREST;
			use_bot_q <= 1'b0;
			bot_x_q   <= '0;
			hist_x_q  <= '0;
			br_cap_q  <= 16'd1024;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_index))
				REG_MAX_GAP: max_gap_q <= cfg_wdata[9:0];
				REG_MODE:    mode_q    <= mode_t'(cfg_wdata[1:0]);
				REG_USE_BOT: use_bot_q <= cfg_wdata[0];
				REG_BOT_X:   bot_x_q   <= cfg_wdata;
				REG_HIST_X:  hist_x_q  <= cfg_wdata;
				REG_BR_CAP:  br_cap_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Input field split.
	logic [9:0] in_row, in_start, in_end;
	logic       in_empty;
	assign in_row   = s_tdata[9:0];
	assign in_empty = s_tdata[10];
	assign in_start = s_tdata[20:11];
	assign in_end   = s_tdata[30:21];

	// Tracking state.
	state_t      state_q, state_d;
	logic [17:0] tracked_q;
	logic        first_pend_q, have_bnd_q, halted_q, dropped_q, from_bot_q;
	logic [9:0]  gap_q, last_l_q, last_r_q, row_q;
	logic [15:0] left_tot_q, right_tot_q;
	logic [NW-1:0] n_q, idx_q;
	logic [AW-1:0] chosen_q;
	logic [17:0] best_q, chosen_c_q;
	logic [9:0]  chosen_lo_q, chosen_hi_q;
	logic        bnd_filled_q;

	// Output register.
	logic        ov_q;
	logic [1:0]  o_kind_q;
	logic [9:0]  o_a_q, o_b_q;
	logic        o_fill_q, o_drop_q, o_last_q;
	logic [9:0]  o_row_q;

	logic accept, out_free, frame_clr, halted_eff;
	assign s_tready = (state_q == ST_IDLE) && !ov_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !ov_q || m_tready;
	assign frame_clr  = accept && s_tuser;
	assign halted_eff = halted_q && !s_tuser;

	// Run buffer.
	logic [19:0] rd;
	logic [AW-1:0] raddr;
	logic buf_we;
	logic [NW-1:0] n_eff, n_new;
	logic [9:0]  gap_base;
	logic        drop_base;
	assign n_eff  = s_tuser ? '0 : n_q;
	assign buf_we = accept && !halted_eff && !in_empty && (n_eff < NMAX);
	assign n_new  = n_eff + NW'(buf_we);
	assign raddr  = idx_q[AW-1:0];
	// A frame start clears the gap count and the drop flag before the beat counts.
	assign gap_base  = s_tuser ? '0 : gap_q;
	assign drop_base = dropped_q && !s_tuser;

	lrbt_ram #(.WIDTH(20), .DEPTH(MAX_RUNS_PER_ROW)) u_ram (
		.clk(clk), .we(buf_we), .waddr(n_eff[AW-1:0]),
		.wdata({in_start, in_end}), .raddr(raddr), .rdata(rd)
	);

	// Shared distance unit.
	logic [10:0] rsum;
	logic [17:0] rc, dref, run_dist, dh_new, dh_old;
	assign rsum = {1'b0, rd[19:10]} + {1'b0, rd[9:0]};
	assign rc   = {rsum, 7'd0};
	function automatic logic [17:0] adiff(input logic [17:0] a, input logic [17:0] b);
		adiff = (a > b) ? a - b : b - a;
	endfunction
	assign dref     = from_bot_q ? bot_x_q : tracked_q;
	assign run_dist = adiff(rc, dref);
	assign dh_new   = adiff(rc, hist_x_q);
	assign dh_old   = adiff(chosen_c_q, hist_x_q);

	logic [NW-1:0] last_idx;
	assign last_idx = n_q - NW'(1);
	logic is_chosen;
	assign is_chosen = (idx_q[AW-1:0] == chosen_q);
	logic go_left, cap_hit;
	assign go_left = rc < tracked_q;
	assign cap_hit = go_left ? (left_tot_q >= br_cap_q) : (right_tot_q >= br_cap_q);

	// The output register loads on a branch or boundary step; a repeated
	// boundary is only shown while the gap allows it.
	logic o_load, o_show;
	assign o_load = out_free && ((state_q == ST_BR && !is_chosen) || state_q == ST_EMIT);
	assign o_show = !(state_q == ST_EMIT && bnd_filled_q) ||
		(have_bnd_q && gap_q <= max_gap_q);

	// Smoothing: a weighted sum of two products.
	logic [26:0] smooth;
	assign smooth = 27'(27'(tracked_q) * 27'd166 + 27'(chosen_c_q) * 27'd90 + 27'd128);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept && !halted_eff && s_tlast) begin
					state_d = (n_new == '0) ? ST_EMIT : ST_SEL_RD;
				end
			ST_SEL_RD: state_d = ST_SEL;
			ST_SEL:    state_d = (idx_q == last_idx) ? ST_BR_RD : ST_SEL_RD;
			ST_BR_RD:  state_d = ST_BR;
			ST_BR:
				if (is_chosen) begin
					state_d = (idx_q == last_idx) ? ST_EMIT : ST_BR_RD;
				end else if (out_free) begin
					state_d = cap_hit ? ST_IDLE :
						((idx_q == last_idx) ? ST_EMIT : ST_BR_RD);
				end
			ST_EMIT:
				if (out_free) begin
					state_d = bnd_filled_q ? ST_IDLE : ST_SMOOTH;
				end
			ST_SMOOTH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath and tracking registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= '0; first_pend_q <= 1'b1; have_bnd_q <= 1'b0;
			halted_q <= 1'b0; dropped_q <= 1'b0; gap_q <= '0;
			last_l_q <= '0; last_r_q <= '0; left_tot_q <= '0; right_tot_q <= '0;
			n_q <= '0; idx_q <= '0; from_bot_q <= 1'b0; chosen_q <= '0;
			bnd_filled_q <= 1'b0; ov_q <= 1'b0; row_q <= '0;
			best_q <= '0; chosen_c_q <= '0; chosen_lo_q <= '0; chosen_hi_q <= '0;
			o_kind_q <= '0; o_a_q <= '0; o_b_q <= '0; o_fill_q <= 1'b0;
			o_drop_q <= 1'b0; o_last_q <= 1'b0; o_row_q <= '0;
		end else begin
			if (o_load) begin
				ov_q <= o_show;
			end else if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:
					if (accept) begin
						if (frame_clr) begin
							tracked_q <= hist_x_q; first_pend_q <= 1'b1;
							have_bnd_q <= 1'b0; last_l_q <= '0; last_r_q <= '0;
							left_tot_q <= '0; right_tot_q <= '0; halted_q <= 1'b0;
						end
						if (!halted_eff) begin
							n_q <= n_new;
							row_q <= in_row;
							idx_q <= '0;
							chosen_q <= '0;
							if (s_tlast && n_new == '0) begin
								bnd_filled_q <= 1'b1;
								dropped_q <= 1'b0;
								gap_q <= (gap_base != 10'h3FF) ? gap_base + 10'd1 : gap_base;
							end else begin
								bnd_filled_q <= 1'b0;
								dropped_q <= drop_base || (!in_empty && n_eff >= NMAX);
								gap_q <= gap_base;
							end
							from_bot_q <= (frame_clr ? 1'b1 : first_pend_q) && use_bot_q
								&& (n_new > NW'(1))
								&& (mode_q == MODE_NEAREST || mode_q == MODE_ALT);
						end
					end
				ST_SEL: begin
					if (idx_q == '0) begin
						best_q <= run_dist; chosen_c_q <= rc; chosen_q <= '0;
						chosen_lo_q <= rd[19:10]; chosen_hi_q <= rd[9:0];
					end else if ((mode_q == MODE_FIRST && n_q > NW'(1)) ||
							(mode_q == MODE_LAST && n_q > NW'(1))) begin
						if (mode_q == MODE_LAST) begin
							chosen_c_q <= rc; chosen_q <= idx_q[AW-1:0];
							chosen_lo_q <= rd[19:10]; chosen_hi_q <= rd[9:0];
						end
					end else if (run_dist < best_q ||
							(run_dist == best_q && from_bot_q && dh_new < dh_old)) begin
						best_q <= run_dist; chosen_c_q <= rc; chosen_q <= idx_q[AW-1:0];
						chosen_lo_q <= rd[19:10]; chosen_hi_q <= rd[9:0];
					end
					idx_q <= (idx_q == last_idx) ? '0 : idx_q + NW'(1);
				end
				ST_BR:
					if (is_chosen) begin
						idx_q <= idx_q + NW'(1);
					end else if (out_free) begin
						o_row_q <= row_q; o_b_q <= '0;
						o_fill_q <= 1'b0; o_drop_q <= dropped_q;
						idx_q <= idx_q + NW'(1);
						if (cap_hit) begin
							o_kind_q <= KIND_OVERFLOW; o_a_q <= '0; o_last_q <= 1'b1;
							halted_q <= 1'b1; n_q <= '0; dropped_q <= 1'b0;
						end else begin
							o_kind_q <= go_left ? KIND_LEFT : KIND_RIGHT;
							o_a_q <= rc[17:8]; o_last_q <= 1'b0;
							if (go_left) left_tot_q <= left_tot_q + 16'd1;
							else right_tot_q <= right_tot_q + 16'd1;
						end
					end
				ST_EMIT:
					if (out_free) begin
						o_kind_q <= KIND_BOUNDARY; o_row_q <= row_q; o_last_q <= 1'b1;
						if (bnd_filled_q) begin
							o_a_q <= last_l_q; o_b_q <= last_r_q;
							o_fill_q <= 1'b1; o_drop_q <= 1'b0;
						end else begin
							o_a_q <= chosen_lo_q; o_b_q <= chosen_hi_q;
							o_fill_q <= 1'b0; o_drop_q <= dropped_q;
							last_l_q <= chosen_lo_q; last_r_q <= chosen_hi_q;
							have_bnd_q <= 1'b1; gap_q <= '0;
						end
					end
				ST_SMOOTH: begin
					tracked_q <= from_bot_q ? chosen_c_q : smooth[25:8];
					first_pend_q <= 1'b0; n_q <= '0; dropped_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {o_drop_q, o_fill_q, o_b_q, o_a_q, o_row_q};
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_kind_q;

	`LRBT_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !s_tready)
	`LRBT_ASSERT_NXT(a_overflow_halts, clk, arst_n,
		m_tvalid && m_tready && m_tuser == KIND_OVERFLOW, halted_q)
	`LRBT_ASSERT_IMP(a_fill_bnd, clk, arst_n, m_tvalid && o_fill_q,
		o_kind_q == KIND_BOUNDARY && o_last_q)
endmodule

// File: src/lrbt_ram.sv
// ---------------------------------------------------------------------------
// lrbt_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lrbt_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: test/lane_row_boundary_tracer_tb.sv
// ---------------------------------------------------------------------------
// lane_row_boundary_tracer_tb
// Self-checking bench: run beats in, predicted boundary and branch beats out.
// ---------------------------------------------------------------------------
// Each accepted input beat is passed through a local model of the lane
// tracker, which queues the result beats that beat should cause. A checker
// process compares every accepted output beat with the oldest queued one.
// Directed tests cover the route modes, gap filling, bottom reference ties,
// dropped runs, branch overflow and a long receiver hold-off; random frames
// follow under several idling phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lane_row_boundary_tracer_tb;
	import lrbt_pkg::*;

	localparam int RUN_SLOTS = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		kind_t       kind;
		logic [9:0]  row;
		logic [9:0]  left_or_center;
		logic [9:0]  right_col;
		logic        filled;
		logic        dropped;
		logic        last;
	} lane_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_wdata;

	lane_row_boundary_tracer dut (.*);

	// Shadow copy of the configuration registers.
	logic [9:0]  gap_limit;
	mode_t       route;
	logic        bottom_en;
	logic [17:0] bottom_x;
	logic [17:0] history_x;
	logic [15:0] branch_cap;

	// Shadow copy of the tracking state.
	logic [17:0] centre_q;
	logic        awaiting_first;
	logic [9:0]  gap_count;
	logic        boundary_known;
	logic [9:0]  prev_left;
	logic [9:0]  prev_right;
	logic [15:0] left_branches;
	logic [15:0] right_branches;
	logic        halted;
	logic [9:0]  row_lo [RUN_SLOTS];
	logic [9:0]  row_hi [RUN_SLOTS];
	int          runs_held;
	logic        overfull;

	lane_beat_t  pending_beats[$];
	int          errors;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;

	always #4 clk = ~clk;

	function automatic logic [17:0] absdiff(input logic [17:0] a, input logic [17:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [17:0] run_centre(input int i);
		return ({8'd0, row_lo[i]} + {8'd0, row_hi[i]}) << 7;
	endfunction

	task automatic clear_tracking();
		centre_q       = history_x;
		awaiting_first = 1'b1;
		gap_count      = '0;
		boundary_known = 1'b0;
		prev_left      = '0;
		prev_right     = '0;
		left_branches  = '0;
		right_branches = '0;
		halted         = 1'b0;
		runs_held      = 0;
		overfull       = 1'b0;
	endtask

	task automatic queue_beat(input kind_t k, input logic [9:0] r, input logic [9:0] a,
			input logic [9:0] b, input logic f, input logic d);
		lane_beat_t e;
		e = '{k, r, a, b, f, d, 1'b0};
		pending_beats.push_back(e);
	endtask

	// Row end: choose the lane run, emit branches in arrival order, then the boundary.
	task automatic close_row(input logic [9:0] r);
		int          n;
		int          chosen;
		logic        drop;
		logic        use_bottom;
		logic [17:0] ref_x;
		logic [17:0] best;
		logic [17:0] d;
		logic [17:0] c;
		logic [27:0] mix;
		mode_t       m;
		n = runs_held;
		drop = overfull;
		chosen = 0;
		runs_held = 0;
		overfull = 1'b0;
		if (n == 0) begin
			if (gap_count != 10'h3FF)
				gap_count++;
			if (gap_count <= gap_limit && boundary_known)
				queue_beat(KIND_BOUNDARY, r, prev_left, prev_right, 1'b1, 1'b0);
			return;
		end
		gap_count = '0;
		m = (route == MODE_ALT) ? MODE_NEAREST : route;
		use_bottom = awaiting_first && n > 1 && bottom_en && m == MODE_NEAREST;
		if (m == MODE_FIRST && n > 1)
			chosen = 0;
		else if (m == MODE_LAST && n > 1)
			chosen = n - 1;
		else begin
			ref_x = use_bottom ? bottom_x : centre_q;
			best = absdiff(run_centre(0), ref_x);
			for (int i = 1; i < n; i++) begin
				d = absdiff(run_centre(i), ref_x);
				if (d < best) begin
					chosen = i;
					best = d;
				end else if (d == best && use_bottom) begin
					if (absdiff(run_centre(i), history_x) <
							absdiff(run_centre(chosen), history_x))
						chosen = i;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			if (i != chosen) begin
				c = run_centre(i);
				if (c < centre_q) begin
					if (left_branches >= branch_cap) begin
						queue_beat(KIND_OVERFLOW, r, '0, '0, 1'b0, drop);
						halted = 1'b1;
						return;
					end
					left_branches++;
					queue_beat(KIND_LEFT, r, c[17:8], '0, 1'b0, drop);
				end else begin
					if (right_branches >= branch_cap) begin
						queue_beat(KIND_OVERFLOW, r, '0, '0, 1'b0, drop);
						halted = 1'b1;
						return;
					end
					right_branches++;
					queue_beat(KIND_RIGHT, r, c[17:8], '0, 1'b0, drop);
				end
			end
		end
		prev_left = row_lo[chosen];
		prev_right = row_hi[chosen];
		boundary_known = 1'b1;
		queue_beat(KIND_BOUNDARY, r, prev_left, prev_right, 1'b0, drop);
		if (use_bottom)
			centre_q = run_centre(chosen);
		else begin
			mix = 28'd166 * centre_q + 28'd90 * run_centre(chosen) + 28'd128;
			centre_q = mix[25:8];
		end
		awaiting_first = 1'b0;
	endtask

	task automatic predict_lane(input logic fs, input logic [9:0] r, input logic empty,
			input logic [9:0] lo, input logic [9:0] hi, input logic eol);
		int queued_before;
		if (fs)
			clear_tracking();
		if (halted)
			return;
		if (!empty) begin
			if (runs_held < RUN_SLOTS) begin
				row_lo[runs_held] = lo;
				row_hi[runs_held] = hi;
				runs_held++;
			end else
				overfull = 1'b1;
		end
		if (!eol)
			return;
		queued_before = pending_beats.size();
		close_row(r);
		if (pending_beats.size() > queued_before)
			pending_beats[pending_beats.size() - 1].last = 1'b1;
	endtask

	// Sends one run beat, idling first at the current rate, and predicts its results.
	// tvalid stays high after the beat; the next beat or drain() takes it down.
	task automatic send_run(input logic fs, input logic [9:0] r, input logic empty,
			input logic [9:0] lo, input logic [9:0] hi, input logic eol);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, hi, lo, empty, r};
		s_tlast  <= eol;
		s_tuser  <= fs;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_lane(fs, r, empty, lo, hi, eol);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input reg_t idx, input logic [17:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAX_GAP: gap_limit  = v[9:0];
			REG_MODE:    route      = mode_t'(v[1:0]);
			REG_USE_BOT: bottom_en  = v[0];
			REG_BOT_X:   bottom_x   = v;
			REG_HIST_X:  history_x  = v;
			REG_BR_CAP:  branch_cap = v[15:0];
			default: ;
		endcase
	endtask

	task automatic setup_all(input int gap, input mode_t m, input logic be,
			input logic [17:0] bx, input logic [17:0] hx, input logic [15:0] cap);
		write_reg(REG_MAX_GAP, 18'(gap));
		write_reg(REG_MODE, 18'(m));
		write_reg(REG_USE_BOT, 18'(be));
		write_reg(REG_BOT_X, bx);
		write_reg(REG_HIST_X, hx);
		write_reg(REG_BR_CAP, 18'(cap));
	endtask

	mode_t route_list[4] = '{MODE_NEAREST, MODE_FIRST, MODE_LAST, MODE_ALT};

	task automatic test_route_modes();
		setup_all(0, MODE_NEAREST, 1'b0, 18'd0, 18'd512 << 8, 16'd1024);
		send_run(1'b1, 10'd0, 1'b0, 10'd0, 10'd0, 1'b0);
		send_run(1'b0, 10'd0, 1'b0, 10'd500, 10'd520, 1'b0);
		send_run(1'b0, 10'd0, 1'b0, 10'd1023, 10'd1023, 1'b1);
		send_run(1'b0, 10'd1, 1'b0, 10'd900, 10'd100, 1'b1);
		drain();
		foreach (route_list[i]) begin
			write_reg(REG_MODE, 18'(route_list[i]));
			send_run(1'b1, 10'd1023, 1'b0, 10'd10, 10'd20, 1'b0);
			send_run(1'b0, 10'd1023, 1'b0, 10'd300, 10'd310, 1'b0);
			send_run(1'b0, 10'd1023, 1'b0, 10'd700, 10'd720, 1'b1);
			drain();
		end
	endtask

	task automatic test_gap_fill();
		setup_all(2, MODE_NEAREST, 1'b0, 18'd0, 18'd100 << 8, 16'd1024);
		send_run(1'b1, 10'd5, 1'b1, 10'd0, 10'd0, 1'b1);
		send_run(1'b0, 10'd6, 1'b0, 10'd90, 10'd110, 1'b1);
		send_run(1'b0, 10'd7, 1'b1, 10'd0, 10'd0, 1'b0);
		send_run(1'b0, 10'd7, 1'b1, 10'd0, 10'd0, 1'b1);
		repeat (3) send_run(1'b0, 10'd8, 1'b1, 10'd0, 10'd0, 1'b1);
		send_run(1'b0, 10'd9, 1'b0, 10'd95, 10'd99, 1'b0);
		send_run(1'b0, 10'd9, 1'b1, 10'd0, 10'd0, 1'b1);
		drain();
		write_reg(REG_MAX_GAP, 18'd1023);
		send_run(1'b0, 10'd10, 1'b1, 10'd0, 10'd0, 1'b1);
		drain();
	endtask

	// Equal distances from the bottom reference are broken by the history centre.
	task automatic test_bottom_reference();
		setup_all(0, MODE_NEAREST, 1'b1, 18'd200 << 8, 18'h3FFFF, 16'd1024);
		send_run(1'b1, 10'd0, 1'b0, 10'd190, 10'd190, 1'b0);
		send_run(1'b0, 10'd0, 1'b0, 10'd210, 10'd210, 1'b0);
		send_run(1'b0, 10'd0, 1'b0, 10'd600, 10'd600, 1'b1);
		send_run(1'b0, 10'd1, 1'b0, 10'd205, 10'd215, 1'b1);
		drain();
	endtask

	task automatic test_dropped_runs();
		setup_all(0, MODE_FIRST, 1'b0, 18'd0, 18'd0, 16'd1024);
		send_run(1'b1, 10'd3, 1'b0, 10'd0, 10'd1, 1'b0);
		for (int i = 1; i < RUN_SLOTS + 3; i++)
			send_run(1'b0, 10'd3, 1'b0, 10'(i * 29), 10'(i * 29 + 5), i == RUN_SLOTS + 2);
		drain();
	endtask

	task automatic test_overflow();
		setup_all(0, MODE_FIRST, 1'b0, 18'd0, 18'd0, 16'd0);
		send_run(1'b1, 10'd1, 1'b0, 10'd10, 10'd20, 1'b0);
		send_run(1'b0, 10'd1, 1'b0, 10'd30, 10'd40, 1'b1);
		send_run(1'b0, 10'd2, 1'b0, 10'd30, 10'd40, 1'b1);
		drain();
		write_reg(REG_BR_CAP, 18'hFFFF);
		send_run(1'b1, 10'd3, 1'b0, 10'd1, 10'd2, 1'b1);
		drain();
	endtask

	// Mostly well-formed frames: a few rows of runs, some empty rows, and noise.
	task automatic random_frames(input int items);
		int sent;
		int nruns;
		logic [9:0] r;
		sent = 0;
		r = 10'($urandom);
		while (sent < items) begin
			nruns = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
			for (int i = 0; i < nruns; i++) begin
				send_run(sent == 0 || $urandom_range(40) == 0, r,
					$urandom_range(15) == 0, 10'($urandom), 10'($urandom),
					(i == nruns - 1) || $urandom_range(30) == 0);
				sent++;
			end
			if (nruns == 0) begin
				send_run($urandom_range(30) == 0, r, 1'b1, 10'($urandom), 10'($urandom), 1'b1);
				sent++;
			end
			r = ($urandom_range(7) == 0) ? 10'($urandom) : r + 10'd1;
		end
		drain();
	endtask

	task automatic test_random();
		int profile[4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{15, 15}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = profile[p][0];
			recv_stall_pct = profile[p][1];
			setup_all($urandom_range(3), mode_t'($urandom_range(3)), 1'($urandom_range(1)),
				18'($urandom), 18'($urandom), 16'($urandom_range(40)));
			random_frames(37);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off while runs keep coming, so the block must stall its input.
	task automatic test_backpressure();
		setup_all(1023, MODE_NEAREST, 1'b0, 18'd0, 18'd400 << 8, 16'hFFFF);
		hold_cycles = 600;
		fork
			for (int i = 0; i < 40; i++)
				send_run(i == 0, 10'(i / 4), 1'b0, 10'($urandom), 10'($urandom), i % 4 == 3);
		join
		drain();
	endtask

	// Output side: random stalls, plus an explicit hold-off counted here.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		lane_beat_t want;
		lane_beat_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind_t'(m_tuser), m_tdata[9:0], m_tdata[19:10], m_tdata[29:20],
				m_tdata[30], m_tdata[31], m_tlast};
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					$display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either side and no register is written.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_GAP;
		cfg_wdata = '0;
		errors = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		gap_limit = '0;
		route = MODE_NEAREST;
		bottom_en = 1'b0;
		bottom_x = '0;
		history_x = '0;
		branch_cap = 16'd1024;
		clear_tracking();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_route_modes();
		test_gap_fill();
		test_bottom_reference();
		test_dropped_runs();
		test_overflow();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
